@@ design/bbd_pkg.sv @@
package bbd_pkg;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int PIXEL_BITS  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_COMP_EE      = 3'd2,
        CFG_COMP_EO      = 3'd3,
        CFG_COMP_OE      = 3'd4,
        CFG_COMP_OO      = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        COMP_RED   = 2'd0,
        COMP_GREEN = 2'd1,
        COMP_BLUE  = 2'd2
    } t_comp;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // geometry of the pixel that a window position produces
    typedef struct packed {
        logic has_out;
        logic rp;
        logic cp;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } t_pix_info;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] red;
        logic [PIXEL_BITS-1:0] green;
        logic [PIXEL_BITS-1:0] blue;
        logic                  last;
    } t_pixel;

endpackage

@@ design/bbd_line_store.sv @@
module bbd_line_store
    import bbd_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/bbd_interp.sv @@
module bbd_interp
    import bbd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  t_pix_info                          i_info,
    input  logic [2:0][2:0][SAMPLE_BITS-1:0]   i_win,
    input  logic [3:0][1:0]                    i_comp,
    output logic                               o_valid,
    output t_pixel                             o_pixel
);

    localparam int SUMW = SAMPLE_BITS + 3;
    localparam int SH   = SUMW + 3;
    localparam int PW   = SUMW + SH;
    localparam longint unsigned POW = 64'd1 << SH;
    localparam logic [SH-1:0] M2 = SH'((POW + 1) / 2);
    localparam logic [SH-1:0] M3 = SH'((POW + 2) / 3);
    localparam logic [SH-1:0] M4 = SH'((POW + 3) / 4);
    localparam logic [SH-1:0] M5 = SH'((POW + 4) / 5);
    localparam logic [SH-1:0] M6 = SH'((POW + 5) / 6);
    localparam logic [SH-1:0] M7 = SH'((POW + 6) / 7);
    localparam logic [SH-1:0] M8 = SH'((POW + 7) / 8);

    logic [2:0][SUMW-1:0]       n_sum;
    logic [2:0][3:0]            n_cnt;
    logic [2:0]                 n_pass;
    logic [2:0][SUMW-1:0]       r_sum;
    logic [2:0][3:0]            r_cnt;
    logic [2:0]                 r_pass;
    logic [SAMPLE_BITS-1:0]     r_center;
    logic                       r_last;
    logic                       r_valid;

    logic [2:0][SUMW-1:0]       num;
    logic [2:0][SH-1:0]         recip;
    logic [2:0][PW-1:0]         prod;
    logic [2:0][SUMW-1:0]       val;

    // same-colour sums over the clipped window
    always_comb begin
        for (int t = 0; t < 3; t++) begin
            n_sum[t]  = '0;
            n_cnt[t]  = '0;
            n_pass[t] = (i_comp[{i_info.rp, i_info.cp}] == 2'(t));
            for (int dr = 0; dr < 3; dr++) begin
                for (int dc = 0; dc < 3; dc++) begin
                    if (((dr == 1) || (dr == 0 && i_info.top_ok) || (dr == 2 && i_info.bot_ok))
                        && ((dc == 1) || (dc == 0 && i_info.left_ok)
                            || (dc == 2 && i_info.right_ok))
                        && (i_comp[{i_info.rp ^ (dr != 1), i_info.cp ^ (dc != 1)}]
                            == 2'(t))) begin
                        n_sum[t] = n_sum[t] + SUMW'(i_win[dr][dc]);
                        n_cnt[t] = n_cnt[t] + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_cnt    <= n_cnt;
        r_pass   <= n_pass;
        r_center <= i_win[1][1];
        r_last   <= i_info.last;
    end

    // rounded average: (sum + cnt/2) / cnt by reciprocal multiply
    always_comb begin
        for (int t = 0; t < 3; t++) begin
            num[t] = r_sum[t] + SUMW'(r_cnt[t] >> 1);
            case (r_cnt[t])
                4'd2:    recip[t] = M2;
                4'd3:    recip[t] = M3;
                4'd4:    recip[t] = M4;
                4'd5:    recip[t] = M5;
                4'd6:    recip[t] = M6;
                4'd7:    recip[t] = M7;
                4'd8:    recip[t] = M8;
                default: recip[t] = '0;
            endcase
            prod[t] = PW'(num[t]) * PW'(recip[t]);
            if (r_pass[t]) begin
                val[t] = SUMW'(r_center);
            end else if (r_cnt[t] == 4'd0) begin
                val[t] = '0;
            end else if (r_cnt[t] == 4'd1) begin
                val[t] = num[t];
            end else begin
                val[t] = prod[t][PW-1:SH];
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel.red   = PIXEL_BITS'(val[COMP_RED]);
    assign o_pixel.green = PIXEL_BITS'(val[COMP_GREEN]);
    assign o_pixel.blue  = PIXEL_BITS'(val[COMP_BLUE]);
    assign o_pixel.last  = r_last;

endmodule

@@ design/bayer_bilinear_demosaic.sv @@
// Bilinear Bayer demosaic, 3x3 window, raster-order stream.
// Input channel: i_valid / o_stall with i_sample; one raw sample per item.
// Output channel: o_valid / i_stall with o_red, o_green, o_blue and
// o_last_of_frame; one RGB pixel per item.
// Each frame of width*height samples is followed by width+1 padding items
// (samples ignored) that flush the last pixels; pixel (r,c) falls due with
// the input item width+1 places later, so the first width+1 items of a
// frame give no pixel.
// Throughput: one item per clock while o_stall is low. After the edge that
// accepts the item completing a pixel's window, the pixel passes through the
// line store read, window shift, sums and divide before o_valid rises.
// Results go through an 8-entry output queue; input keeps flowing while the
// receiver stalls, and o_stall rises only in reset or when the queue plus the
// pixels in flight would fill it.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while
// the block is idle. Reset clears the counters, the window and the queue and
// loads width and height 4096 and the RGGB pattern; line stores hold
// whatever they held, since no unwritten entry reaches an output.
module bayer_bilinear_demosaic
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_HEIGHT  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [15:0]            i_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [PIXEL_BITS-1:0]  o_red,
    output logic [PIXEL_BITS-1:0]  o_green,
    output logic [PIXEL_BITS-1:0]  o_blue,
    output logic                   o_last_of_frame,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [CFG_DATA_W-1:0]  r_frame_width;
    logic [CFG_DATA_W-1:0]  r_frame_height;
    logic [3:0][1:0]        r_comp;

    logic [WW-1:0]          w_eff;
    logic [HW-1:0]          h_eff;

    logic [RW-1:0]          r_row;
    logic [CW-1:0]          r_col;
    logic [RW-1:0]          n_row;
    logic [CW-1:0]          n_col;

    logic                   accept;
    logic                   pad;
    logic                   col_nz;
    logic [RW-1:0]          orow;
    logic [CW-1:0]          ocol;
    t_pix_info              info;
    logic [SAMPLE_BITS-1:0] in_s;

    logic                   r_s1_valid;
    logic                   r_s1_fwd;
    logic [CW-1:0]          r_s1_idx;
    logic [SAMPLE_BITS-1:0] r_s1_bot;
    t_pix_info              r_s1_info;

    logic [SAMPLE_BITS-1:0] top_rd;
    logic [SAMPLE_BITS-1:0] mid_rd;
    logic [SAMPLE_BITS-1:0] top_eff;
    logic [SAMPLE_BITS-1:0] mid_eff;
    logic [SAMPLE_BITS-1:0] r_wr_up;
    logic [SAMPLE_BITS-1:0] r_wr_mid;

    logic [2:0][2:0][SAMPLE_BITS-1:0] r_win;
    logic                   r_s2_valid;
    t_pix_info              r_s2_info;

    logic                   s3_valid;
    t_pixel                 s3_pixel;

    t_pixel                 r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic [FIFO_CNT_W:0]    pending;
    logic                   pop;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_DATA_W'(4096);
            r_frame_height <= CFG_DATA_W'(4096);
            r_comp[0]      <= COMP_RED;
            r_comp[1]      <= COMP_GREEN;
            r_comp[2]      <= COMP_GREEN;
            r_comp[3]      <= COMP_BLUE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_COMP_EE:      r_comp[0]      <= i_cfg_data[1:0];
                CFG_COMP_EO:      r_comp[1]      <= i_cfg_data[1:0];
                CFG_COMP_OE:      r_comp[2]      <= i_cfg_data[1:0];
                CFG_COMP_OO:      r_comp[3]      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_frame_height);
        end
    end

    // position of the incoming item and of the pixel it completes
    assign accept = i_valid && !o_stall;
    assign in_s   = SAMPLE_BITS'(i_sample);
    assign pad    = (RW+1)'(r_row) >= (RW+1)'(h_eff);
    assign col_nz = (r_col != '0);
    assign orow   = col_nz ? r_row - RW'(1) : r_row - RW'(2);
    assign ocol   = col_nz ? r_col - CW'(1) : CW'(w_eff - WW'(1));

    always_comb begin
        if (col_nz) begin
            info.has_out = (r_row != '0)
                && ((RW+1)'(r_row) <= (RW+1)'(h_eff))
                && ((WW+1)'(r_col) <= (WW+1)'(w_eff));
        end else begin
            info.has_out = ((RW+1)'(r_row) >= (RW+1)'(2))
                && ((RW+1)'(r_row) <= (RW+1)'(h_eff) + (RW+1)'(1));
        end
        info.rp       = orow[0];
        info.cp       = ocol[0];
        info.top_ok   = (orow != '0);
        info.bot_ok   = ((RW+1)'(orow) + (RW+1)'(1)) < (RW+1)'(h_eff);
        info.left_ok  = (ocol != '0);
        info.right_ok = ((WW+1)'(ocol) + (WW+1)'(1)) < (WW+1)'(w_eff);
        info.last     = (((RW+1)'(orow) + (RW+1)'(1)) == (RW+1)'(h_eff))
                     && (((WW+1)'(ocol) + (WW+1)'(1)) == (WW+1)'(w_eff));
    end

    always_comb begin
        if ((RW+1)'(r_row) >= (RW+1)'(h_eff) + (RW+1)'(1)) begin
            n_row = '0;
            n_col = '0;
        end else if ((WW+1)'(r_col) + (WW+1)'(1) >= (WW+1)'(w_eff)) begin
            n_row = r_row + RW'(1);
            n_col = '0;
        end else begin
            n_row = r_row;
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // stage 1: line store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_bot  <= pad ? '0 : in_s;
            r_s1_idx  <= r_col;
            r_s1_fwd  <= r_s1_valid && (r_s1_idx == r_col);
            r_s1_info <= info;
        end
    end

    bbd_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (SAMPLE_BITS)
    ) u_upper (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (top_rd),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (mid_eff)
    );

    bbd_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (SAMPLE_BITS)
    ) u_middle (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (mid_rd),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (r_s1_bot)
    );

    // same column written on the edge it was read (width of one)
    assign top_eff = r_s1_fwd ? r_wr_up  : top_rd;
    assign mid_eff = r_s1_fwd ? r_wr_mid : mid_rd;

    // stage 2: window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= top_eff;
                r_win[1][2] <= mid_eff;
                r_win[2][2] <= r_s1_bot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_wr_up   <= mid_eff;
            r_wr_mid  <= r_s1_bot;
            r_s2_info <= r_s1_info;
        end
    end

    // stages 3 and 4: sums and averages
    bbd_interp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid && r_s2_info.has_out),
        .i_info  (r_s2_info),
        .i_win   (r_win),
        .i_comp  (r_comp),
        .o_valid (s3_valid),
        .o_pixel (s3_pixel)
    );

    // output queue
    assign pop = (r_count != '0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s3_valid) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (s3_valid && !pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (!s3_valid && pop) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_valid) begin
            r_fifo[r_wr_ptr] <= s3_pixel;
        end
    end

    assign pending = (FIFO_CNT_W+1)'(r_count)
                   + (FIFO_CNT_W+1)'(r_s1_valid && r_s1_info.has_out)
                   + (FIFO_CNT_W+1)'(r_s2_valid && r_s2_info.has_out)
                   + (FIFO_CNT_W+1)'(s3_valid);

    assign o_stall         = !i_rst_n || (pending >= (FIFO_CNT_W+1)'(FIFO_DEPTH));
    assign o_valid         = (r_count != '0);
    assign o_red           = r_fifo[r_rd_ptr].red;
    assign o_green         = r_fifo[r_rd_ptr].green;
    assign o_blue          = r_fifo[r_rd_ptr].blue;
    assign o_last_of_frame = r_fifo[r_rd_ptr].last;

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    import bbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM        = 4096;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PRINT_CAP      = 100;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int TEST_WIDTH_MAX = 40;
    localparam logic [1:0] COMP_NONE = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [15:0]            i_sample;
    logic                   o_valid;
    logic                   i_stall;
    logic [PIXEL_BITS-1:0]  o_red;
    logic [PIXEL_BITS-1:0]  o_green;
    logic [PIXEL_BITS-1:0]  o_blue;
    logic                   o_last_of_frame;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    bayer_bilinear_demosaic dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // predictor state
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [1:0]            pattern [4];
    logic [15:0]           upper_line [MAX_DIM];
    logic [15:0]           middle_line [MAX_DIM];
    logic [15:0]           win_pix [3][3];
    int                    row_pos;
    int                    col_pos;

    t_pixel      pending_pixels [$];
    int unsigned mismatch_count;
    int unsigned items_sent;
    bit          no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("[bayer_bilinear_demosaic] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic int eff_dim(input logic [CFG_DATA_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic [1:0] colour_of(input int r, input int c);
        return pattern[{r[0], c[0]}];
    endfunction

    function automatic logic [15:0] window_avg(input logic [1:0] colour, input int orow,
                                               input int ocol, input int w, input int h);
        int unsigned sum;
        int unsigned cnt;
        int rr;
        int cc;
        sum = 0;
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = orow + dr;
                cc = ocol + dc;
                if (rr >= 0 && rr < h && cc >= 0 && cc < w && colour_of(rr, cc) == colour) begin
                    sum += win_pix[dr + 1][dc + 1];
                    cnt++;
                end
            end
        end
        if (cnt == 0) return 16'd0;
        return 16'((sum + cnt / 2) / cnt);
    endfunction

    task automatic reset_predictor();
        width_reg  = 13'd4096;
        height_reg = 13'd4096;
        pattern[0] = COMP_RED;
        pattern[1] = COMP_GREEN;
        pattern[2] = COMP_GREEN;
        pattern[3] = COMP_BLUE;
        for (int k = 0; k < MAX_DIM; k++) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                win_pix[r][c] = '0;
            end
        end
        row_pos = 0;
        col_pos = 0;
    endtask

    task automatic demosaic_step(input logic [15:0] value);
        int w;
        int h;
        int orow;
        int ocol;
        logic [15:0] bot;
        logic [15:0] top;
        logic [15:0] mid;
        logic [1:0]  own;
        t_pixel px;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        bot = (row_pos >= h) ? 16'd0 : value;
        top = upper_line[col_pos];
        mid = middle_line[col_pos];
        upper_line[col_pos]  = mid;
        middle_line[col_pos] = bot;
        for (int r = 0; r < 3; r++) begin
            win_pix[r][0] = win_pix[r][1];
            win_pix[r][1] = win_pix[r][2];
        end
        win_pix[0][2] = top;
        win_pix[1][2] = mid;
        win_pix[2][2] = bot;

        if (col_pos >= 1) begin
            orow = row_pos - 1;
            ocol = col_pos - 1;
        end else begin
            orow = row_pos - 2;
            ocol = w - 1;
        end

        if (orow >= 0 && orow < h && ocol < w) begin
            own = colour_of(orow, ocol);
            px.red   = (own == COMP_RED) ? win_pix[1][1] : window_avg(COMP_RED, orow, ocol, w, h);
            px.green = (own == COMP_GREEN) ? win_pix[1][1]
                                           : window_avg(COMP_GREEN, orow, ocol, w, h);
            px.blue  = (own == COMP_BLUE) ? win_pix[1][1] : window_avg(COMP_BLUE, orow, ocol, w, h);
            px.last  = (orow == h - 1 && ocol == w - 1);
            pending_pixels.push_back(px);
        end

        if (row_pos >= h + 1) begin
            row_pos = 0;
            col_pos = 0;
        end else if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
    endtask

    // output side: random stall ahead of each pixel
    initial begin : stall_driver
        int gap;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : pixel_check
        t_pixel want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("pixel with none expected");
            end else begin
                want = pending_pixels.pop_front();
                if (o_red !== want.red)
                    report_mismatch($sformatf("red %h, expected %h", o_red, want.red));
                if (o_green !== want.green)
                    report_mismatch($sformatf("green %h, expected %h", o_green, want.green));
                if (o_blue !== want.blue)
                    report_mismatch($sformatf("blue %h, expected %h", o_blue, want.blue));
                if (o_last_of_frame !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", o_last_of_frame, want.last));
            end
        end
    end

    task automatic send_sample(input logic [15:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        demosaic_step(value);
        items_sent++;
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_FRAME_WIDTH:  width_reg  = data;
            CFG_FRAME_HEIGHT: height_reg = data;
            CFG_COMP_EE:      pattern[0] = data[1:0];
            CFG_COMP_EO:      pattern[1] = data[1:0];
            CFG_COMP_OE:      pattern[2] = data[1:0];
            CFG_COMP_OO:      pattern[3] = data[1:0];
            default: ;
        endcase
    endtask

    task automatic write_pattern(input logic [1:0] ee, input logic [1:0] eo,
                                 input logic [1:0] oe, input logic [1:0] oo);
        write_reg(CFG_COMP_EE, CFG_DATA_W'(ee));
        write_reg(CFG_COMP_EO, CFG_DATA_W'(eo));
        write_reg(CFG_COMP_OE, CFG_DATA_W'(oe));
        write_reg(CFG_COMP_OO, CFG_DATA_W'(oo));
    endtask

    // wait until all pixels are out, then let the pipeline empty
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] rand_comp();
        if ($urandom_range(0, 7) == 0) return COMP_NONE;
        return 2'($urandom_range(COMP_RED, COMP_BLUE));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_dim(input int max_dim);
        if ($urandom_range(0, 15) == 0) return '0;
        return CFG_DATA_W'($urandom_range(1, max_dim));
    endfunction

    // finishes the frame in progress, padding included
    task automatic run_frame();
        do send_sample(rand_sample()); while (row_pos != 0 || col_pos != 0);
    endtask

    // frame as wide as TEST_WIDTH_MAX, beyond which no later test reads a line
    // store entry, so every entry read later holds a known value
    task automatic test_line_fill();
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(TEST_WIDTH_MAX));
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        run_frame();
        settle();
    endtask

    task automatic test_sample_extremes();
        logic [15:0] vals [12] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002,
                                   16'hFFFF, 16'h0000, 16'hFFFE, 16'h0003,
                                   16'h0001, 16'h8000, 16'hFFFF, 16'h7FFF};
        write_pattern(COMP_RED, COMP_GREEN, COMP_GREEN, COMP_BLUE);
        write_reg(CFG_FRAME_WIDTH, 13'd4);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        foreach (vals[k]) send_sample(vals[k]);
        run_frame();
        settle();
    endtask

    task automatic test_colour_patterns();
        write_reg(CFG_FRAME_WIDTH, 13'd2);
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        write_pattern(COMP_GREEN, COMP_RED, COMP_BLUE, COMP_GREEN);
        run_frame();
        settle();
        write_pattern(COMP_BLUE, COMP_GREEN, COMP_GREEN, COMP_RED);
        run_frame();
        settle();
        // no colour matches code 3
        write_pattern(COMP_NONE, COMP_NONE, COMP_NONE, COMP_NONE);
        run_frame();
        settle();
        write_pattern(COMP_NONE, COMP_GREEN, COMP_BLUE, COMP_RED);
        run_frame();
        settle();
        write_pattern(COMP_RED, COMP_GREEN, COMP_GREEN, COMP_BLUE);
    endtask

    task automatic test_geometry_change();
        write_reg(CFG_FRAME_WIDTH, 13'd5);
        write_reg(CFG_FRAME_HEIGHT, 13'd4);
        repeat (7) send_sample(rand_sample());
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        repeat (5) send_sample(rand_sample());
        settle();
        // row counter now past height+1: next item wraps the frame
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        repeat (3) send_sample(rand_sample());
        settle();
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        run_frame();
        settle();
    endtask

    // oversized settings clamp to the maximum, zero counts as one
    task automatic test_dim_clamps();
        write_reg(CFG_FRAME_WIDTH, 13'd8191);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        repeat (20) send_sample(rand_sample());
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        write_reg(CFG_FRAME_HEIGHT, 13'd8191);
        repeat (20) send_sample(rand_sample());
        settle();
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        run_frame();
        settle();
    endtask

    task automatic test_tall_frame();
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        write_reg(CFG_FRAME_HEIGHT, 13'd40);
        run_frame();
        settle();
    endtask

    task automatic test_random_frames();
        int unsigned start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            settle();
            no_gaps = ($urandom_range(0, 3) == 0);
            write_reg(CFG_FRAME_WIDTH,
                      rand_dim($urandom_range(0, 7) == 0 ? TEST_WIDTH_MAX : 12));
            write_reg(CFG_FRAME_HEIGHT, rand_dim(8));
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(0, 1) == 0)
                    write_reg(t_cfg_index'(CFG_COMP_EE + k), CFG_DATA_W'(rand_comp()));
            end
            // partial frames leave the next setting to land mid-frame
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 30)) send_sample(rand_sample());
            end else begin
                repeat ($urandom_range(1, 2)) run_frame();
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= '0;
        mismatch_count = 0;
        items_sent     = 0;
        no_gaps        = 1'b0;
        reset_predictor();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_line_fill();
        test_sample_extremes();
        test_colour_patterns();
        test_geometry_change();
        test_dim_clamps();
        test_tall_frame();
        test_random_frames();
        settle();

        if (mismatch_count == 0) begin
            $display("[bayer_bilinear_demosaic] OK");
        end else begin
            $display("[bayer_bilinear_demosaic] ERROR");
        end
        $finish;
    end

endmodule
